[design/bps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitplane pixel serializer package
// Shared widths, request and mode codes, and the pixel word type.
// ----------------------------------------------------------------------------
package bps_pkg;

	localparam int PLANE_W    = 16;
	localparam int NUM_PLANES = 4;
	localparam int SLOT_W     = 2;
	localparam int CNT_W      = 6;
	localparam int COLOR_W    = 4;
	localparam int MODE_W     = 2;
	localparam int TOP_BIT    = PLANE_W - 1;

	// Request codes carried in req_type.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_LOAD  = 1'b1;

	// Display modes.
	localparam logic [MODE_W-1:0] MODE_FOUR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TWO   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ONE   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_BLANK = 2'd3;

	// Pixel counts at which the shift registers are refilled.
	localparam logic [CNT_W-1:0] CNT_REFILL_A = 6'd16;
	localparam logic [CNT_W-1:0] CNT_REFILL_B = 6'd32;
	localparam logic [CNT_W-1:0] CNT_REFILL_C = 6'd48;

	localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd3;

	typedef logic [PLANE_W-1:0] plane_t;

	typedef struct packed {
		logic [COLOR_W-1:0] color_index;
		logic               blank;
	} pixel_t;

endpackage

[design/bps_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel interface
// Carries pixel ticks and plane word loads with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bps_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] plane_word;

	modport source (output valid, output req_type, output plane_word, input ready);
	modport sink   (input valid, input req_type, input plane_word, output ready);
endinterface

[design/bps_pix_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel channel interface
// Carries one palette index and blank flag per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bps_pix_if;
	logic       valid;
	logic       ready;
	logic [3:0] color_index;
	logic       blank;

	modport source (output valid, output color_index, output blank, input ready);
	modport sink   (input valid, input color_index, input blank, output ready);
endinterface

[design/bitplane_pixel_serializer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitplane pixel serializer
// Turns planar video words into 4-bit palette indices, one pixel per word.
// ----------------------------------------------------------------------------
// Usage:
// The req channel takes words of two kinds. A load word (req_type 1) carries
// one 16-bit plane word; four loads fill the plane latches and the fourth one
// copies them into the shift registers. A load produces no output word.
// A pixel tick (req_type 1'b0) shifts one pixel out and produces exactly one
// word on the pix channel: color_index and blank.
// display_mode is written through cfg_we/cfg_wdata while the block is idle.
// A pixel tick passes through the input register and then the output register
// before its word is valid on pix. Throughput is one word per cycle while pix
// does not stall; the input register and the output register are both advanced
// in the same cycle, so a new word is accepted while the previous pixel is
// still waiting to be taken. When pix stalls, the held pixel stays in the
// output register, one more pixel tick may sit in the input register, and
// req.ready then drops. Loads keep flowing past a stalled output since they
// produce nothing.
// Reset clears all planes, latches, the slot, the counter and the mode.
// ----------------------------------------------------------------------------
module bitplane_pixel_serializer (
	input  logic                        clk,
	input  logic                        arst_n,
	bps_req_if.sink                     req,
	bps_pix_if.source                   pix,
	input  logic                        cfg_we,
	input  logic [bps_pkg::MODE_W-1:0]  cfg_wdata
);
	import bps_pkg::*;

	// Configuration register.
	logic [MODE_W-1:0] display_mode_q;

	// Input register stage.
	logic              valid_s1;
	logic              req_type_s1;
	plane_t            plane_word_s1;

	// Output register.
	logic              out_valid_q;
	pixel_t            out_pixel_q;

	logic              out_free;
	logic              advance;
	logic              take_in;
	pixel_t            pixel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			display_mode_q <= MODE_FOUR;
		end else if (cfg_we) begin
			display_mode_q <= cfg_wdata;
		end
	end

	// The output register can load when it is empty or being emptied now.
	assign out_free = !out_valid_q || pix.ready;
	// A load word never needs the output, so it always leaves stage one.
	assign advance  = valid_s1 && (req_type_s1 == REQ_LOAD || out_free);
	assign req.ready = !valid_s1 || advance;
	assign take_in  = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			req_type_s1   <= req.req_type;
			plane_word_s1 <= req.plane_word;
		end
	end

	bps_plane_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (advance),
		.req_type     (req_type_s1),
		.plane_word   (plane_word_s1),
		.display_mode (display_mode_q),
		.pixel        (pixel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && req_type_s1 == REQ_PIXEL) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && req_type_s1 == REQ_PIXEL) begin
			out_pixel_q <= pixel;
		end
	end

	assign pix.valid       = out_valid_q;
	assign pix.color_index = out_pixel_q.color_index;
	assign pix.blank       = out_pixel_q.blank;

endmodule

[design/bps_plane_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Plane engine
// Holds the plane latches, shift registers, latch slot and pixel counter, and
// computes the pixel for the current word and the state after it.
// ----------------------------------------------------------------------------
module bps_plane_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic                        req_type,
	input  bps_pkg::plane_t             plane_word,
	input  logic [bps_pkg::MODE_W-1:0]  display_mode,
	output bps_pkg::pixel_t             pixel
);
	import bps_pkg::*;

	plane_t              shift_q [NUM_PLANES];
	plane_t              latch_q [NUM_PLANES];
	logic [SLOT_W-1:0]   slot_q;
	logic [CNT_W-1:0]    count_q;

	plane_t              shift_d [NUM_PLANES];
	plane_t              latch_d [NUM_PLANES];
	logic [SLOT_W-1:0]   slot_d;
	logic [CNT_W-1:0]    count_d;
	logic [CNT_W-1:0]    count_inc;

	assign count_inc = count_q + CNT_W'(1);

	always_comb begin
		shift_d = shift_q;
		latch_d = latch_q;
		slot_d  = slot_q;
		count_d = count_q;
		pixel   = '0;

		if (req_type == REQ_LOAD) begin
			latch_d[slot_q] = plane_word;
			slot_d          = slot_q + SLOT_W'(1);
			// The fourth word completes a group: all planes move to the shifters.
			if (slot_q == SLOT_LAST) begin
				shift_d = latch_d;
			end
		end else begin
			case (display_mode)
				MODE_FOUR: begin
					pixel.color_index = {shift_q[3][TOP_BIT], shift_q[2][TOP_BIT],
						shift_q[1][TOP_BIT], shift_q[0][TOP_BIT]};
					for (int k = 0; k < NUM_PLANES; k++) begin
						shift_d[k] = {shift_q[k][TOP_BIT-1:0], 1'b0};
					end
				end
				MODE_TWO: begin
					pixel.color_index = {2'b00, shift_q[1][TOP_BIT], shift_q[0][TOP_BIT]};
					shift_d[0] = {shift_q[0][TOP_BIT-1:0], 1'b0};
					shift_d[1] = {shift_q[1][TOP_BIT-1:0], 1'b0};
					count_d    = count_inc;
					if (count_inc == CNT_REFILL_A) begin
						shift_d[0] = shift_q[2];
						shift_d[1] = shift_q[3];
						shift_d[2] = '0;
						shift_d[3] = '0;
						count_d    = '0;
					end
				end
				MODE_ONE: begin
					pixel.color_index = {3'b000, shift_q[0][TOP_BIT]};
					shift_d[0] = {shift_q[0][TOP_BIT-1:0], 1'b0};
					count_d    = count_inc;
					if (count_inc == CNT_REFILL_A) begin
						shift_d[0] = shift_q[1];
						shift_d[1] = shift_q[2];
						shift_d[2] = shift_q[3];
						shift_d[3] = '0;
					end else if (count_inc == CNT_REFILL_B) begin
						shift_d[0] = shift_q[1];
						shift_d[1] = shift_q[2];
						shift_d[2] = '0;
					end else if (count_inc == CNT_REFILL_C) begin
						shift_d[0] = shift_q[1];
						shift_d[1] = '0;
						count_d    = '0;
					end
				end
				default: begin
					pixel.blank = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PLANES; k++) begin
				shift_q[k] <= '0;
				latch_q[k] <= '0;
			end
			slot_q  <= '0;
			count_q <= '0;
		end else if (fire) begin
			shift_q <= shift_d;
			latch_q <= latch_d;
			slot_q  <= slot_d;
			count_q <= count_d;
		end
	end

`ifndef SYNTHESIS
	a_group_copy: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == REQ_LOAD && slot_q == SLOT_LAST
		|=> shift_q[3] == $past(plane_word) && shift_q[0] == $past(latch_q[0]))
		else $error("plane group not copied into shifters");

	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(count_q) && $stable(slot_q) && shift_q[0] == $past(shift_q[0]))
		else $error("engine state moved without a word");

	a_one_refill: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == REQ_PIXEL && display_mode == MODE_ONE
			&& count_q == CNT_REFILL_C - CNT_W'(1)
		|=> count_q == '0 && shift_q[1] == '0 && shift_q[0] == $past(shift_q[1]))
		else $error("one-plane cycle did not wrap");

	a_load_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		fire && req_type == REQ_LOAD |=> $stable(count_q))
		else $error("pixel counter moved on a load");
`endif

endmodule
